[rtl/rdc_pkg.sv]
// ----------------------------------------------------------------------------
// rdc_pkg
// shared constants, types and helper functions of the radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int MAX_DIGITS  = 31;

	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 6;
	localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
	localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
	localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_STORE,
		ST_EMIT
	} st_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic store;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic quo_zero;
		logic out_free;
		logic emit_last;
	} sts_t;

	// saturate the raw register to the supported base range
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

[rtl/rdc_in_if.sv]
// ----------------------------------------------------------------------------
// rdc_in_if
// input channel: one binary value per transaction
// ----------------------------------------------------------------------------
interface rdc_in_if import rdc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[rtl/rdc_out_if.sv]
// ----------------------------------------------------------------------------
// rdc_out_if
// output channel: one ascii character per transaction
// ----------------------------------------------------------------------------
interface rdc_out_if import rdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

[rtl/rdc_ctrl.sv]
// ----------------------------------------------------------------------------
// rdc_ctrl
// sequencer: divide, store digit, repeat until quotient is zero, then emit
// ----------------------------------------------------------------------------
module rdc_ctrl import rdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = sts.quo_zero ? ST_EMIT : ST_DIVIDE;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIVIDE: cmd.step  = 1'b1;
			ST_STORE:  cmd.store = 1'b1;
			ST_EMIT:   cmd.emit  = sts.out_free;
			default:   cmd       = '0;
		endcase
	end

endmodule

[rtl/rdc_datapath.sv]
// ----------------------------------------------------------------------------
// rdc_datapath
// radix register, bit-serial restoring divider, digit buffer, output register
// ----------------------------------------------------------------------------
module rdc_datapath import rdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RADIX_W-1:0]     cfg_wdata,
	input  logic [VALUE_WIDTH-1:0] value,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last
);

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_IDX_W-1:0]   wptr_q;
	logic [DIG_IDX_W-1:0]   rptr_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic [DIG_CNT_W-1:0]   emit_left_q;
	logic [DIGIT_W-1:0]     digits_q [MAX_DIGITS];
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic [RADIX_W-1:0]     rad;
	logic [DIGIT_W:0]       trial;
	logic                   ge;
	logic [DIG_CNT_W-1:0]   cnt_next;

	assign rad      = eff_radix(radix_q);
	assign trial    = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge       = trial >= {1'b0, rad};
	assign cnt_next = (dig_cnt_q == DIG_CNT_W'(MAX_DIGITS)) ? dig_cnt_q
	                  : dig_cnt_q + DIG_CNT_W'(1);

	assign sts.div_last  = bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1);
	assign sts.quo_zero  = quo_q == '0;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.emit_last = emit_left_q == DIG_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// restoring divider, one quotient bit per cycle, and digit buffer write
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q     <= value;
			rem_q     <= '0;
			bit_cnt_q <= '0;
			wptr_q    <= '0;
			dig_cnt_q <= '0;
		end else if (cmd.step) begin
			quo_q     <= {quo_q[VALUE_WIDTH-2:0], ge};
			rem_q     <= ge ? DIGIT_W'(trial - {1'b0, rad}) : DIGIT_W'(trial);
			bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
		end else if (cmd.store) begin
			digits_q[wptr_q] <= rem_q;
			wptr_q    <= (wptr_q == DIG_IDX_W'(MAX_DIGITS - 1)) ? '0
			             : wptr_q + DIG_IDX_W'(1);
			dig_cnt_q <= cnt_next;
			rem_q     <= '0;
			bit_cnt_q <= '0;
		end
	end

	// read back newest digit first
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			rptr_q      <= wptr_q;
			emit_left_q <= cnt_next;
		end else if (cmd.emit) begin
			rptr_q      <= (rptr_q == '0) ? DIG_IDX_W'(MAX_DIGITS - 1)
			               : rptr_q - DIG_IDX_W'(1);
			emit_left_q <= emit_left_q - DIG_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= digit_to_ascii(digits_q[rptr_q]);
			last_q <= emit_left_q == DIG_CNT_W'(1);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

[rtl/radix_digit_converter.sv]
// ----------------------------------------------------------------------------
// radix_digit_converter
// binary to ascii text in a configurable base from 2 to 36
// ----------------------------------------------------------------------------
// Each value transaction on value_ch becomes a run of ascii characters on
// char_ch, most significant digit first, with last set on the final one;
// zero gives the single character '0'. Digits 0-9 map to '0'-'9' and 10-35
// to 'A'-'Z'. The base comes from the 6-bit register written through
// cfg_we/cfg_wdata (reset 10); 0 and 1 act as 2, anything above 36 acts as
// 36. Write it only while the block is idle. One value is converted at a
// time: a shared restoring divider produces one quotient bit per cycle, so
// each digit takes VALUE_WIDTH = 31 divide steps plus one digit store, and a
// value with n digits holds value_ch.ready low through those n rounds and n
// emits, plus any output stall, with up to 31 digits in base 2. The last
// character sits in an output register, so the next value is taken while
// that character still waits for char_ch.ready.
module radix_digit_converter import rdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata,
	rdc_in_if.sink             value_ch,
	rdc_out_if.source          char_ch
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: owns value_ch.ready, idle only between runs
	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_ch.valid),
		.in_ready (value_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: radix register, divider, digit buffer and output register
	rdc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.value      (value_ch.value),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (char_ch.ready),
		.out_valid  (char_ch.valid),
		.digit_char (char_ch.digit_char),
		.last       (char_ch.last)
	);

endmodule

[rtl/rdc_checker.sv]
// ----------------------------------------------------------------------------
// rdc_checker
// port-level checks of the radix digit converter, bound to the top level
// ----------------------------------------------------------------------------
module rdc_checker import rdc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] digit_char,
	input logic              last
);

	// a stalled output transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
		else $error("output changed while stalled");

	// only digit and upper-case letter codes leave the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) ||
		              (digit_char >= 7'd65 && digit_char <= 7'd90))
		else $error("character outside digit alphabet");

	// a new value is never taken back to back
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second value accepted during conversion");

	// when ready for a value, only the final character of a run may wait
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("ready for input with a run still pending");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (value_ch.valid),
	.in_ready   (value_ch.ready),
	.out_valid  (char_ch.valid),
	.out_ready  (char_ch.ready),
	.digit_char (char_ch.digit_char),
	.last       (char_ch.last)
);
